[src/audio_frame_format_converter_defines.svh]
// Assertion macros for the audio frame format converter.
`ifndef AUDIO_FRAME_FORMAT_CONVERTER_DEFINES_SVH
`define AUDIO_FRAME_FORMAT_CONVERTER_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define AFFC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define AFFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/affc_pkg.sv]
// ----------------------------------------------------------------------------
// affc_pkg
// Shared types, constants and sample conversion for the format converter.
// ----------------------------------------------------------------------------
package affc_pkg;

    localparam int MAX_CHANNELS       = 8;
    localparam int MAX_BLOCK_FRAMES   = 8192;
    localparam int MAX_UPSAMPLE_RATIO = 24;

    localparam int FRAME_W = 14;
    localparam int SUM_W   = 27;
    localparam int RUN_W   = 5;

    localparam logic [1:0] CFG_SRC_CH    = 2'd0;
    localparam logic [1:0] CFG_DST_CH    = 2'd1;
    localparam logic [1:0] CFG_SRC_FLOAT = 2'd2;
    localparam logic [1:0] CFG_DST_FLOAT = 2'd3;

    typedef struct packed {
        logic [31:0] in_sample_7;
        logic [31:0] in_sample_6;
        logic [31:0] in_sample_5;
        logic [31:0] in_sample_4;
        logic [31:0] in_sample_3;
        logic [31:0] in_sample_2;
        logic [31:0] in_sample_1;
        logic [31:0] in_sample_0;
        logic [13:0] block_src_frames;
        logic [13:0] block_dst_frames;
    } t_in_word;

    typedef struct packed {
        logic [31:0] out_sample_7;
        logic [31:0] out_sample_6;
        logic [31:0] out_sample_5;
        logic [31:0] out_sample_4;
        logic [31:0] out_sample_3;
        logic [31:0] out_sample_2;
        logic [31:0] out_sample_1;
        logic [31:0] out_sample_0;
        logic        last_of_run;
        logic        block_done;
    } t_out_word;

    // Controller to datapath.
    typedef struct packed {
        logic load;   // latch input word, start block if at position zero
        logic emit;   // push one destination frame
        logic finish; // advance source position
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic more;   // another destination frame maps to this source frame
    } t_status;

    function automatic logic [3:0] clamp_ch(input logic [3:0] n);
        logic [3:0] r;
        r = n;
        if (n == 4'd0) r = 4'd1;
        else if (n > 4'(MAX_CHANNELS)) r = 4'(MAX_CHANNELS);
        return r;
    endfunction

    function automatic logic [13:0] clamp_frames(input logic [13:0] n);
        logic [13:0] r;
        r = n;
        if (n == 14'd0) r = 14'd1;
        else if (n > 14'(MAX_BLOCK_FRAMES)) r = 14'(MAX_BLOCK_FRAMES);
        return r;
    endfunction

    // int16 -> float32, s * 2^-15 exactly.
    function automatic logic [31:0] i16_to_f32(input logic [15:0] s);
        logic        sg;
        logic [15:0] m;
        logic [4:0]  msb;
        logic [31:0] r;
        logic [22:0] frac;
        sg   = s[15];
        m    = sg ? 16'(-s) : s;
        msb  = 5'd0;
        r    = 32'd0;
        frac = 23'd0;
        for (int i = 0; i < 16; i++) begin
            if (m[i]) msb = 5'(i);
        end
        if (m != 16'd0) begin
            frac = 23'({m, 7'd0} << (5'd16 - msb));
            r = {sg, 8'(8'd112 + 8'(msb)), frac};
        end
        return r;
    endfunction

    // float32 -> int16: round(v*32767) to float, truncate, saturate, NaN -> 0.
    function automatic logic [15:0] f32_to_i16(input logic [31:0] f);
        logic        sg;
        logic [7:0]  ex;
        logic [23:0] mant;
        logic [38:0] prod;
        logic [24:0] pm;
        logic [8:0]  pe;
        logic        lsb, gd, st;
        logic [24:0] rm;
        logic [15:0] mag;
        logic [16:0] wide;
        logic [15:0] r;
        sg   = f[31];
        ex   = f[30:23];
        mant = {1'b1, f[22:0]};
        r    = 16'd0;
        prod = mant * 15'd32767;
        // product in [2^23*32767, 2^24*32767): normalise to 24 bits
        if (prod[38]) begin
            pm  = {1'b0, prod[38:15]};
            lsb = prod[15]; gd = prod[14]; st = |prod[13:0];
            pe  = 9'(ex) + 9'd15;
        end else begin
            pm  = {1'b0, prod[37:14]};
            lsb = prod[14]; gd = prod[13]; st = |prod[12:0];
            pe  = 9'(ex) + 9'd14;
        end
        rm = pm + 25'(gd & (st | lsb));
        if (rm[24]) begin
            rm = rm >> 1;
            pe = pe + 9'd1;
        end
        // value = rm * 2^(pe-127-23)
        if (ex == 8'hFF) begin
            if (f[22:0] != 23'd0) r = 16'd0;
            else r = sg ? 16'h8000 : 16'h7FFF;
        end else if (ex == 8'd0) begin
            r = 16'd0; // denormal inputs give |p| < 1
        end else if (pe >= 9'd142) begin
            r = sg ? 16'h8000 : 16'h7FFF;
        end else if (pe < 9'd127) begin
            r = 16'd0;
        end else begin
            mag  = 16'(rm[23:0] >> (9'd150 - pe));
            wide = {1'b0, mag};
            if (!sg) r = (wide >= 17'd32767) ? 16'h7FFF : mag;
            else r = (wide >= 17'd32768) ? 16'h8000 : 16'(-mag);
        end
        return r;
    endfunction

endpackage

[src/audio_frame_format_converter.sv]
// ----------------------------------------------------------------------------
// audio_frame_format_converter
// Nearest-neighbour frame resampler with int16 / float32 sample conversion.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake             | Payload
// in      | sink      | i_in_valid/o_in_stall  | t_in_word
// out     | source    | o_out_valid/i_out_stall| t_out_word
// cfg     | sink      | i_cfg_we               | i_cfg_idx, i_cfg_data
//
// Each source word yields N (0..24) destination frames; the single output
// register sets one frame per cycle while the output is not stalled.
// Synchronous active-low reset restores the default format registers and
// clears the block position. A stalled output holds emission in place; the
// input is stalled while a word is being worked on.
module audio_frame_format_converter
    import affc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [3:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_word   i_in,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_word  o_out
);

    t_cmd    cmd;
    t_status status;
    logic    out_free;

    affc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_out_free (out_free),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    affc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_free  (out_free),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

[src/affc_ctrl.sv]
// ----------------------------------------------------------------------------
// affc_ctrl
// Sequencer: load a source word, emit its destination frames, then finish.
// ----------------------------------------------------------------------------
`include "audio_frame_format_converter_defines.svh"
module affc_ctrl
    import affc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  logic    i_out_free,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN
    } t_state;

    t_state r_state;

    assign o_in_stall = (r_state != ST_IDLE);

    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_IDLE: o_cmd.load = i_in_valid;
            ST_RUN: begin
                o_cmd.emit   = i_status.more & i_out_free;
                o_cmd.finish = ~i_status.more;
            end
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            case (r_state)
                ST_IDLE: if (i_in_valid) r_state <= ST_RUN;
                ST_RUN:  if (!i_status.more) r_state <= ST_IDLE;
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    `AFFC_ASSERT_IMPL(a_one_cmd, i_clk, i_rst_n, 1'b1, $onehot0(o_cmd), "commands overlap")
    `AFFC_ASSERT_IMPL(a_load_idle, i_clk, i_rst_n, o_cmd.load, r_state == ST_IDLE,
        "load outside idle")
    `AFFC_ASSERT_NEXT(a_finish_idle, i_clk, i_rst_n, o_cmd.finish, r_state == ST_IDLE,
        "finish did not return to idle")

endmodule

[src/affc_dp.sv]
// ----------------------------------------------------------------------------
// affc_dp
// Datapath: block position sums, sample conversion and output register.
// ----------------------------------------------------------------------------
module affc_dp
    import affc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [3:0] i_cfg_data,
    input  t_in_word  i_in,
    input  t_cmd      i_cmd,
    output t_status   o_status,
    output logic      o_out_free,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out
);

    logic [3:0]          r_src_ch, r_dst_ch;
    logic                r_src_f, r_dst_f;
    logic [FRAME_W-2:0]  r_src_pos;
    logic [FRAME_W-1:0]  r_dst_pos, r_s, r_d;
    logic [SUM_W-1:0]    r_dsum, r_lsum;
    logic [RUN_W-1:0]    r_n;
    logic [31:0]         r_conv [MAX_CHANNELS];
    logic                r_out_valid;
    t_out_word           r_out;
    logic [FRAME_W-1:0]  n_s, n_d;
    logic [31:0]         raw [MAX_CHANNELS];
    logic [31:0]         n_conv [MAX_CHANNELS];
    logic [3:0]          sch, dch;
    logic [FRAME_W-1:0]  dst_next;
    logic [18:0]         cap;

    assign raw[0] = i_in.in_sample_0;
    assign raw[1] = i_in.in_sample_1;
    assign raw[2] = i_in.in_sample_2;
    assign raw[3] = i_in.in_sample_3;
    assign raw[4] = i_in.in_sample_4;
    assign raw[5] = i_in.in_sample_5;
    assign raw[6] = i_in.in_sample_6;
    assign raw[7] = i_in.in_sample_7;

    assign sch = clamp_ch(r_src_ch);
    assign dch = clamp_ch(r_dst_ch);

    always_comb begin
        n_s = clamp_frames(i_in.block_src_frames);
        n_d = clamp_frames(i_in.block_dst_frames);
        cap = 19'(n_s) * 19'(MAX_UPSAMPLE_RATIO);
        if (19'(n_d) > cap) n_d = FRAME_W'(cap);
    end

    // Convert each destination channel from its mapped source channel.
    always_comb begin
        for (int c = 0; c < MAX_CHANNELS; c++) begin
            logic [31:0] s;
            s = raw[(4'(c) < sch) ? 3'(c) : 3'(sch - 4'd1)];
            if (4'(c) >= dch) n_conv[c] = 32'd0;
            else if (r_src_f && r_dst_f) n_conv[c] = s;
            else if (!r_src_f && !r_dst_f) begin
                if (s[15]) n_conv[c] = {16'd0, 16'(s[15:0] + 16'd1)};
                else if (s[15:0] != 16'd0) n_conv[c] = {16'd0, 16'(s[15:0] - 16'd1)};
                else n_conv[c] = 32'd0;
            end else if (!r_src_f) n_conv[c] = i16_to_f32(s[15:0]);
            else n_conv[c] = {16'd0, f32_to_i16(s)};
        end
    end

    assign o_status.more = (r_n != RUN_W'(MAX_UPSAMPLE_RATIO)) && (r_dst_pos < r_d)
                           && (r_dsum < r_lsum);
    assign o_out_free = !r_out_valid || !i_out_stall;
    assign dst_next = r_dst_pos + 14'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_ch <= 4'd2; r_dst_ch <= 4'd2; r_src_f <= 1'b1; r_dst_f <= 1'b1;
            r_src_pos <= '0; r_dst_pos <= '0; r_dsum <= '0; r_lsum <= '0;
            r_s <= '0; r_d <= '0; r_n <= '0; r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SRC_CH:    r_src_ch <= i_cfg_data;
                    CFG_DST_CH:    r_dst_ch <= i_cfg_data;
                    CFG_SRC_FLOAT: r_src_f  <= i_cfg_data[0];
                    CFG_DST_FLOAT: r_dst_f  <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
            if (i_cmd.load) begin
                r_n <= '0;
                if (r_src_pos == '0) begin
                    r_s <= n_s; r_d <= n_d;
                    r_dst_pos <= '0; r_dsum <= '0; r_lsum <= SUM_W'(n_d);
                end
            end
            if (i_cmd.emit) begin
                r_n       <= r_n + 5'd1;
                r_dst_pos <= dst_next;
                r_dsum    <= r_dsum + SUM_W'(r_s);
                r_out_valid <= 1'b1;
            end
            if (i_cmd.finish) begin
                if (14'(r_src_pos) + 14'd1 >= r_s) begin
                    r_src_pos <= '0; r_dst_pos <= '0; r_dsum <= '0; r_lsum <= '0;
                end else begin
                    r_src_pos <= r_src_pos + 13'd1;
                    r_lsum    <= r_lsum + SUM_W'(r_d);
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int c = 0; c < MAX_CHANNELS; c++) r_conv[c] <= n_conv[c];
        end
        if (i_cmd.emit) begin
            r_out.out_sample_0 <= r_conv[0];
            r_out.out_sample_1 <= r_conv[1];
            r_out.out_sample_2 <= r_conv[2];
            r_out.out_sample_3 <= r_conv[3];
            r_out.out_sample_4 <= r_conv[4];
            r_out.out_sample_5 <= r_conv[5];
            r_out.out_sample_6 <= r_conv[6];
            r_out.out_sample_7 <= r_conv[7];
            r_out.block_done   <= (dst_next == r_d);
            // last of run: next frame would cross the limit, hit D or the cap
            r_out.last_of_run  <= (r_n == 5'(MAX_UPSAMPLE_RATIO - 1)) || (dst_next >= r_d)
                                  || (r_dsum + SUM_W'(r_s) >= r_lsum);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out = r_out;

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for audio_frame_format_converter: drives blocks of source
// frames under several channel and format settings, predicts each destination
// frame and compares every output word field by field.
// ----------------------------------------------------------------------------

module tb
    import affc_pkg::*;
();

    // Resampler predictor and store of expected destination frames.
    class frame_scoreboard;
        logic [3:0] src_ch_reg, dst_ch_reg;
        logic       src_flt, dst_flt;
        longint     src_pos, dst_pos, scaled_sum, limit_sum, held_s, held_d;
        t_out_word  expected_q[$];
        int         errors;
        int         frames_seen;
        int         words_seen;

        function new();
            src_ch_reg = 4'd2;
            dst_ch_reg = 4'd2;
            src_flt    = 1'b1;
            dst_flt    = 1'b1;
            src_pos    = 0;
            dst_pos    = 0;
            scaled_sum = 0;
            limit_sum  = 0;
            held_s     = 0;
            held_d     = 0;
            errors     = 0;
            frames_seen = 0;
            words_seen = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [3:0] val);
            case (idx)
                CFG_SRC_CH:    src_ch_reg = val;
                CFG_DST_CH:    dst_ch_reg = val;
                CFG_SRC_FLOAT: src_flt = val[0];
                CFG_DST_FLOAT: dst_flt = val[0];
                default: ;
            endcase
        endfunction

        static function int eff_channels(logic [3:0] n);
            if (n == 4'd0) return 1;
            if (n > 4'd8) return 8;
            return int'(n);
        endfunction

        static function longint eff_frames(logic [13:0] n);
            if (n == 14'd0) return 1;
            if (n > 14'd8192) return 8192;
            return longint'(n);
        endfunction

        // Exact s / 32768 as float32 bits.
        static function logic [31:0] pcm_to_float(logic [15:0] s);
            logic [16:0] mag;
            int          top;
            logic [40:0] shifted;
            mag = s[15] ? 17'(-$signed({s[15], s})) : {1'b0, s};
            if (mag == 17'd0) return 32'd0;
            top = 0;
            for (int i = 0; i < 17; i++) if (mag[i]) top = i;
            shifted = 41'(mag) << (23 - top);
            return {s[15], 8'(127 + top - 15), shifted[22:0]};
        endfunction

        // Float32 bits times 32767, rounded to float, truncated, saturated.
        static function logic [15:0] float_to_pcm(logic [31:0] f);
            logic [7:0]  ex;
            longint      prod, r;
            int          len, sh, k;
            longint      mag, rem, half;
            ex = f[30:23];
            if (ex == 8'hFF) begin
                if (f[22:0] != 0) return 16'd0;
                return f[31] ? 16'h8000 : 16'h7FFF;
            end
            if (ex == 8'd0) return 16'd0;
            prod = longint'({1'b1, f[22:0]}) * 32767;
            len = 0;
            for (int i = 0; i < 40; i++) if (prod[i]) len = i + 1;
            sh   = len - 24;
            r    = prod >> sh;
            rem  = prod - (r << sh);
            half = longint'(1) << (sh - 1);
            if (rem > half || (rem == half && r[0])) r = r + 1;
            if (r == (longint'(1) << 24)) begin
                r  = r >> 1;
                sh = sh + 1;
            end
            k = int'(ex) - 150 + sh;
            if (k >= 16) mag = 40000;
            else if (k >= 0) mag = r << k;
            else if (k <= -25) mag = 0;
            else mag = r >> (-k);
            if (!f[31]) return (mag >= 32767) ? 16'h7FFF : 16'(mag);
            return (mag >= 32768) ? 16'h8000 : 16'(-mag);
        endfunction

        function logic [31:0] convert(logic [31:0] raw);
            logic signed [15:0] s;
            if (src_flt && dst_flt) return raw;
            if (!src_flt && !dst_flt) begin
                s = raw[15:0];
                if (s > 0) s = s - 1;
                else if (s < 0) s = s + 1;
                return {16'd0, s};
            end
            if (!src_flt) return pcm_to_float(raw[15:0]);
            return {16'd0, float_to_pcm(raw)};
        endfunction

        // Note an accepted source frame and queue the destination frames it yields.
        function void note_source(t_in_word w);
            logic [31:0] raw[8];
            logic [31:0] conv[8];
            int          sch, dch, n;
            t_out_word   o;
            raw = '{w.in_sample_0, w.in_sample_1, w.in_sample_2, w.in_sample_3,
                    w.in_sample_4, w.in_sample_5, w.in_sample_6, w.in_sample_7};
            sch = eff_channels(src_ch_reg);
            dch = eff_channels(dst_ch_reg);
            n = 0;
            words_seen++;
            if (src_pos == 0) begin
                held_s = eff_frames(w.block_src_frames);
                held_d = eff_frames(w.block_dst_frames);
                if (held_d > held_s * 24) held_d = held_s * 24;
                dst_pos = 0;
                scaled_sum = 0;
                limit_sum = held_d;
            end
            for (int c = 0; c < 8; c++)
                conv[c] = (c < dch) ? convert(raw[(c < sch) ? c : sch - 1]) : 32'd0;
            while (n < 24 && dst_pos < held_d && scaled_sum < limit_sum) begin
                o = '{conv[7], conv[6], conv[5], conv[4], conv[3], conv[2], conv[1],
                      conv[0], 1'b0, 1'b0};
                dst_pos++;
                scaled_sum += held_s;
                o.block_done = (dst_pos == held_d);
                expected_q.insert(expected_q.size(), o);
                n++;
            end
            if (n > 0) expected_q[expected_q.size() - 1].last_of_run = 1'b1;
            src_pos++;
            limit_sum += held_d;
            if (src_pos >= held_s) begin
                src_pos = 0;
                dst_pos = 0;
                scaled_sum = 0;
                limit_sum = 0;
            end
        endfunction

        function void check_frame(t_out_word got);
            t_out_word want;
            frames_seen++;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected frame %h", $time, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (want.out_sample_0 !== got.out_sample_0)
                report("out_sample_0", want.out_sample_0, got.out_sample_0);
            if (want.out_sample_1 !== got.out_sample_1)
                report("out_sample_1", want.out_sample_1, got.out_sample_1);
            if (want.out_sample_2 !== got.out_sample_2)
                report("out_sample_2", want.out_sample_2, got.out_sample_2);
            if (want.out_sample_3 !== got.out_sample_3)
                report("out_sample_3", want.out_sample_3, got.out_sample_3);
            if (want.out_sample_4 !== got.out_sample_4)
                report("out_sample_4", want.out_sample_4, got.out_sample_4);
            if (want.out_sample_5 !== got.out_sample_5)
                report("out_sample_5", want.out_sample_5, got.out_sample_5);
            if (want.out_sample_6 !== got.out_sample_6)
                report("out_sample_6", want.out_sample_6, got.out_sample_6);
            if (want.out_sample_7 !== got.out_sample_7)
                report("out_sample_7", want.out_sample_7, got.out_sample_7);
            if (want.last_of_run !== got.last_of_run)
                report("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
            if (want.block_done !== got.block_done)
                report("block_done", 32'(want.block_done), 32'(got.block_done));
        endfunction

        function void report(string field, logic [31:0] want, logic [31:0] got);
            errors++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 600000;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [3:0] i_cfg_data;
    logic       i_in_valid;
    logic       o_in_stall;
    t_in_word   i_in;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out_word  o_out;

    frame_scoreboard sb;
    int cycles = 0;
    int words_sent;
    int stall_left = 0;
    logic stall_mode = 1'b0;

    audio_frame_format_converter u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog: abandon the run if the block hangs.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL");
            $finish;
        end
    end

    // Observe both handshakes at the edge; values are those before the edge updates.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) sb.note_source(i_in);
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_frame(o_out);
    end

    // Receiver back-pressure: runs of free flow and stalls, mostly short, a few long.
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= ~stall_mode;
            if ($urandom_range(0, 9) == 0) stall_left <= $urandom_range(15, 60);
            else stall_left <= $urandom_range(1, 4);
            i_out_stall <= ~stall_mode && ($urandom_range(0, 3) != 0);
        end else begin
            stall_left <= stall_left - 1;
            i_out_stall <= stall_mode;
        end
    end

    // Write one register; the enable is left high for a following write.
    task automatic write_reg(logic [1:0] idx, logic [3:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        sb.set_reg(idx, val);
        @(posedge i_clk);
    endtask

    task automatic set_format(logic [3:0] sch, logic [3:0] dch, logic sf, logic df);
        write_reg(CFG_SRC_CH, sch);
        write_reg(CFG_DST_CH, dch);
        write_reg(CFG_SRC_FLOAT, {3'd0, sf});
        write_reg(CFG_DST_FLOAT, {3'd0, df});
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Hold the sender until every word is noted and every expected frame is out,
    // then let the block settle.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.words_seen != words_sent || sb.expected_q.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // Offer one source word after a random gap and hold it until accepted.
    task automatic send_word(t_in_word w);
        int gap;
        case ($urandom_range(0, 19))
            0:       gap = $urandom_range(20, 50);
            1, 2, 3: gap = $urandom_range(1, 3);
            default: gap = 0;
        endcase
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= w;
        do @(posedge i_clk); while (o_in_stall);
        words_sent++;
    endtask

    // Sample mix weighted towards the conversion corners.
    function automatic logic [31:0] pick_sample();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 9))
            0: return r;
            1: return {r[31], 8'hFF, 1'b1, r[21:0]};           // NaN
            2: return {r[31], 8'hFF, 23'd0};                   // infinity
            3: return {r[31], 8'h00, r[22:0]};                 // denormal or zero
            4: return {r[31], 8'd126 + 8'(r[0]), r[22:0]};     // near unity
            5: return {r[31], 8'(100 + r[4:0]), r[22:0]};      // small magnitudes
            6: return {r[31], 8'(128 + r[3:0]), r[22:0]};      // saturating
            7: begin
                case (r[1:0])
                    2'd0: return {r[31:16], 16'h8000};
                    2'd1: return {r[31:16], 16'h7FFF};
                    2'd2: return {r[31:16], 16'h0001};
                    default: return {r[31:16], 16'hFFFF};
                endcase
            end
            default: return r;
        endcase
    endfunction

    // Send one whole block; the counts ride on the first word only.
    task automatic send_block(logic [13:0] s_raw, logic [13:0] d_raw);
        t_in_word w;
        longint   frames;
        frames = sb.eff_frames(s_raw);
        for (longint f = 0; f < frames; f++) begin
            w.in_sample_0 = pick_sample();
            w.in_sample_1 = pick_sample();
            w.in_sample_2 = pick_sample();
            w.in_sample_3 = pick_sample();
            w.in_sample_4 = pick_sample();
            w.in_sample_5 = pick_sample();
            w.in_sample_6 = pick_sample();
            w.in_sample_7 = pick_sample();
            w.block_src_frames = (f == 0) ? s_raw : 14'($urandom);
            w.block_dst_frames = (f == 0) ? d_raw : 14'($urandom);
            send_word(w);
        end
    endtask

    task automatic random_blocks(int budget);
        int s, d;
        while (budget > 0) begin
            s = $urandom_range(1, 6);
            case ($urandom_range(0, 9))
                0:       d = 0;
                1:       d = $urandom_range(8193, 16383);
                2, 3, 4: d = $urandom_range(1, s);
                default: d = $urandom_range(s, s * 24 + 4);
            endcase
            if ($urandom_range(0, 15) == 0) s = 0;
            send_block(14'(s), 14'(d));
            budget -= (s == 0) ? 1 : s;
        end
    endtask

    initial begin
        sb = new();
        words_sent  = 0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = CFG_SRC_CH;
        i_cfg_data  = 4'd0;
        i_in_valid  = 1'b0;
        i_in        = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset format, zero counts, ratio clamp, downsampling gaps.
        send_block(14'd0, 14'd0);
        send_block(14'd1, 14'd16383);
        send_block(14'd5, 14'd2);
        send_block(14'd3, 14'd3);
        send_block(14'd2, 14'd48);
        drain();
        set_format(4'd0, 4'd15, 1'b0, 1'b1);
        send_block(14'd4, 14'd7);
        send_block(14'd2, 14'd1);
        drain();

        set_format(4'd8, 4'd8, 1'b1, 1'b0);
        random_blocks(25);
        drain();
        set_format(4'd15, 4'd1, 1'b0, 1'b0);
        random_blocks(25);
        drain();
        set_format(4'd1, 4'd8, 1'b1, 1'b0);
        random_blocks(25);
        drain();
        set_format(4'd3, 4'd5, 1'b0, 1'b1);
        random_blocks(25);
        drain();
        set_format(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                   1'($urandom), 1'($urandom));
        random_blocks(25);
        drain();
        set_format(4'd8, 4'd1, 1'b1, 1'b1);
        random_blocks(10);
        drain();

        $display("sent %0d source words, checked %0d destination frames",
                 sb.words_seen, sb.frames_seen);
        $display("covered all four format pairs, channel clamps and resampling ratios");
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
